### rtl/core/rdn_pkg.sv
// ----------------------------------------------------------------------------
// Relative difference norm package
// Shared widths, norm kind codes and the work descriptor passed from the
// accumulating front end to the finishing back end.
// ----------------------------------------------------------------------------
package rdn_pkg;

    localparam int DATA_W = 24;
    localparam int ACC_W  = 64;
    localparam int OUT_W  = 48;
    localparam int KIND_W = 2;

    localparam int DEFAULT_MAX_LENGTH = 4096;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam logic [ACC_W-1:0] ONE_Q16 = 64'd65536;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_INF    = 2'd0,
        KIND_L1     = 2'd1,
        KIND_L2     = 2'd2,
        KIND_UNUSED = 2'd3
    } norm_kind_t;

    // Finished accumulation for one vector pair.
    typedef struct packed {
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
        norm_kind_t       kind;
    } job_t;

endpackage

### rtl/core/rdn_front.sv
// ----------------------------------------------------------------------------
// Relative difference norm front end
// Accepts one element pair a beat, forms |a-b| and |a| (or their squares),
// updates the saturating accumulators and emits a job on the last element.
// ----------------------------------------------------------------------------
module rdn_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdn_pkg::norm_kind_t         kind,
    input  logic                        in_fire,
    input  logic signed [23:0]          a_value,
    input  logic signed [23:0]          b_value,
    input  logic                        last,
    output logic                        job_valid,
    output rdn_pkg::job_t               job
);
    import rdn_pkg::*;

    logic [ACC_W-1:0] num_reg, num_next;
    logic [ACC_W-1:0] den_reg, den_next;
    logic signed [DATA_W:0] diff;
    logic [DATA_W:0]  ad;
    logic [DATA_W:0]  aa;
    logic [2*DATA_W+1:0] ad_sq;
    logic [2*DATA_W+1:0] aa_sq;
    logic [ACC_W:0]   sum_n;
    logic [ACC_W:0]   sum_d;
    logic [ACC_W-1:0] add_n;
    logic [ACC_W-1:0] add_d;

    // Magnitudes of the difference and of the reference element.
    always_comb
    begin
        diff = DATA_W'(0) + ({a_value[DATA_W-1], a_value} - {b_value[DATA_W-1], b_value});
        ad   = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
        aa   = a_value[DATA_W-1] ? (DATA_W+1)'(-{a_value[DATA_W-1], a_value})
                                 : (DATA_W+1)'({1'b0, a_value});
        ad_sq = ad * ad;
        aa_sq = aa * aa;
    end

    // Accumulator update by norm kind.
    always_comb
    begin
        unique case (kind)
            KIND_L2:
            begin
                add_n = ACC_W'(ad_sq);
                add_d = ACC_W'(aa_sq);
            end
            default:
            begin
                add_n = ACC_W'(ad);
                add_d = ACC_W'(aa);
            end
        endcase
        sum_n = {1'b0, num_reg} + {1'b0, add_n};
        sum_d = {1'b0, den_reg} + {1'b0, add_d};
        num_next = num_reg;
        den_next = den_reg;
        unique case (kind)
            KIND_INF:
            begin
                if (add_n > num_reg) num_next = add_n;
                if (add_d > den_reg) den_next = add_d;
            end
            KIND_L1, KIND_L2:
            begin
                num_next = sum_n[ACC_W] ? {ACC_W{1'b1}} : sum_n[ACC_W-1:0];
                den_next = sum_d[ACC_W] ? {ACC_W{1'b1}} : sum_d[ACC_W-1:0];
            end
            default:
            begin
                num_next = num_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (in_fire)
        begin
            num_reg <= last ? '0 : num_next;
            den_reg <= last ? '0 : den_next;
        end
    end

    assign job_valid = in_fire && last;
    assign job.num   = num_next;
    assign job.den   = den_next;
    assign job.kind  = kind;

endmodule

### rtl/core/rdn_queue.sv
// ----------------------------------------------------------------------------
// Relative difference norm job queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module rdn_queue #(
    parameter int DEPTH = rdn_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rdn_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output rdn_pkg::job_t rd_data,
    output logic          empty
);
    import rdn_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !empty)
        else $error("queue full and empty together");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    assert property (@(posedge clk) disable iff (!rst_n) wr_en && !rd_en |=> !empty)
        else $error("queue empty after a write");

endmodule

### rtl/core/rdn_back.sv
// ----------------------------------------------------------------------------
// Relative difference norm back end
// Takes a finished job, takes L2 square roots one bit a cycle, then if D > 2^16
// the quotient N*2^16/D one bit a cycle (else N), held until it is popped.
// ----------------------------------------------------------------------------
module rdn_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_avail,
    input  rdn_pkg::job_t       job,
    output logic                job_take,
    output logic                empty,
    input  logic                pop,
    output logic [47:0]         norm_value,
    output logic                relative
);
    import rdn_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQRT = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    // Square root working registers; two roots run side by side.
    logic [ACC_W-1:0] xn_reg, xd_reg;
    logic [ACC_W-1:0] rn_reg, rd_reg;
    logic [ACC_W-1:0] bit_reg;
    logic [ACC_W-1:0] n_reg, d_reg;
    logic [ACC_W-1:0] rem_reg;
    logic [OUT_W-1:0] quo_reg;
    logic [6:0]       cnt_reg;
    logic             rel_reg;
    logic             has_out_reg;
    logic [OUT_W-1:0] out_reg;
    logic [ACC_W:0]   tn, td;
    logic [ACC_W:0]   rem_sh;
    logic             take_bit;
    logic             out_free;

    assign out_free = !has_out_reg || pop;
    assign job_take = (state_reg == ST_IDLE) && job_avail;
    assign empty      = !has_out_reg;
    assign norm_value = out_reg;
    assign relative   = rel_reg;

    always_comb
    begin
        tn = {1'b0, rn_reg} + {1'b0, bit_reg};
        td = {1'b0, rd_reg} + {1'b0, bit_reg};
        rem_sh = {rem_reg, n_reg[ACC_W-1]};
        take_bit = rem_sh >= {1'b0, d_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_avail) state_next = (job.kind == KIND_L2) ? ST_SQRT : ST_PREP;
            ST_SQRT: if (bit_reg[1:0] != 2'b00) state_next = ST_PREP;
            ST_PREP: state_next = (d_reg > ONE_Q16) ? ST_DIV : ST_DONE;
            ST_DIV:  if (cnt_reg == 7'd79 || cnt_reg == 7'd100) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            has_out_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
                has_out_reg <= 1'b1;
            else if (pop)
                has_out_reg <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                xn_reg  <= job.num;
                xd_reg  <= job.den;
                rn_reg  <= '0;
                rd_reg  <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
                n_reg   <= (job.kind == KIND_UNUSED) ? '0 : job.num;
                d_reg   <= (job.kind == KIND_UNUSED) ? '0 : job.den;
            end
            ST_SQRT:
            begin
                if ({1'b0, xn_reg} >= tn)
                begin
                    xn_reg <= xn_reg - tn[ACC_W-1:0];
                    rn_reg <= (rn_reg >> 1) + bit_reg;
                end
                else
                    rn_reg <= rn_reg >> 1;
                if ({1'b0, xd_reg} >= td)
                begin
                    xd_reg <= xd_reg - td[ACC_W-1:0];
                    rd_reg <= (rd_reg >> 1) + bit_reg;
                end
                else
                    rd_reg <= rd_reg >> 1;
                bit_reg <= bit_reg >> 2;
                if (bit_reg[1:0] != 2'b00)
                begin
                    n_reg <= ({1'b0, xn_reg} >= tn) ? (rn_reg >> 1) + bit_reg : rn_reg >> 1;
                    d_reg <= ({1'b0, xd_reg} >= td) ? (rd_reg >> 1) + bit_reg : rd_reg >> 1;
                end
            end
            ST_PREP:
            begin
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                // Restoring division over the 80-bit dividend N*2^16.
                rem_reg <= take_bit ? ACC_W'(rem_sh - {1'b0, d_reg}) : rem_sh[ACC_W-1:0];
                quo_reg <= {quo_reg[OUT_W-2:0], take_bit};
                n_reg   <= {n_reg[ACC_W-2:0], 1'b0};
                // Any quotient bit above the 48 kept saturates and ends the division.
                if (cnt_reg < 7'd32 && take_bit)
                    cnt_reg <= 7'd100;
                else if (cnt_reg != 7'd100)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (d_reg > ONE_Q16)
                    begin
                        out_reg <= (cnt_reg == 7'd100) ? OUT_MAX : quo_reg;
                        rel_reg <= 1'b1;
                    end
                    else
                    begin
                        out_reg <= (n_reg > {16'd0, OUT_MAX}) ? OUT_MAX : n_reg[OUT_W-1:0];
                        rel_reg <= 1'b0;
                    end
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) job_take |-> state_reg == ST_IDLE)
        else $error("job taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_free |=> !empty)
        else $error("finished result not shown");
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");

endmodule

### rtl/core/relative_difference_norm.sv
// ----------------------------------------------------------------------------
// Relative difference norm
// Streams element pairs, accumulates the difference norm and the reference
// norm, and reports the absolute or relative error per vector pair.
// ----------------------------------------------------------------------------
// Channel  | Handshake       | Beat
// input    | push / full     | a_value, b_value, last
// result   | pop / empty     | norm_value, relative
// config   | cfg_valid/ready | cfg_data (norm_kind)
//
// Elements are taken one a cycle while the input is not full. A vector end
// passes the back end through taking the job, the L2 square roots, set-up,
// the bit-serial quotient (only for a reference norm above 1.0) and
// presenting the result; a saturating quotient ends early. QUEUE_DEPTH
// finished vectors (two by default) can queue while the back end works;
// input stalls only when that queue is full.
// Reset clears the accumulators, the queue and norm_kind (infinity norm).
// ----------------------------------------------------------------------------
module relative_difference_norm #(
    parameter int QUEUE_DEPTH = rdn_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [23:0]  a_value,
    input  logic signed [23:0]  b_value,
    input  logic                last,
    output logic                empty,
    input  logic                pop,
    output logic [47:0]         norm_value,
    output logic                relative,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);
    import rdn_pkg::*;

    norm_kind_t kind_reg;
    logic       in_fire;
    logic       job_valid;
    job_t       job_in;
    job_t       job_out;
    logic       q_empty;
    logic       job_take;

    assign cfg_ready = 1'b1;
    assign in_fire   = push && !full;

    // Norm kind register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_INF;
        else if (cfg_valid)
            kind_reg <= norm_kind_t'(cfg_data);
    end

    rdn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (kind_reg),
        .in_fire   (in_fire),
        .a_value   (a_value),
        .b_value   (b_value),
        .last      (last),
        .job_valid (job_valid),
        .job       (job_in)
    );

    rdn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job_in),
        .full    (full),
        .rd_en   (job_take),
        .rd_data (job_out),
        .empty   (q_empty)
    );

    rdn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_avail  (!q_empty),
        .job        (job_out),
        .job_take   (job_take),
        .empty      (empty),
        .pop        (pop),
        .norm_value (norm_value),
        .relative   (relative)
    );

endmodule

### tb/sv/relative_difference_norm_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relative difference norm testbench
// Streams vector pairs through every norm kind and compares each reported
// error beat, in order, with a cycle-free model of the accumulators and the
// finishing arithmetic. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module relative_difference_norm_test;

    import rdn_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  BACK_END_CYCLES = 150;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct {
        logic [47:0] norm_value;
        logic        relative;
    } norm_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [23:0] a_value = '0;
    logic signed [23:0] b_value = '0;
    logic               last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [47:0]        norm_value;
    logic               relative;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_data = '0;

    // Model state: accumulators and the kind in force.
    logic [63:0]  diff_sum;
    logic [63:0]  ref_sum;
    norm_kind_t   model_kind;

    norm_beat_t   pending_norms[$];
    int           mismatches = 0;
    longint       cycles = 0;
    bit           quiet = 1'b0;

    relative_difference_norm i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .a_value    (a_value),
        .b_value    (b_value),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .norm_value (norm_value),
        .relative   (relative),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // Clock generation.
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Floor square root, bit by bit.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] probe;
        root = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > x)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (x >= root + probe)
            begin
                x = x - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Quotient in Q.16, saturated to the output width.
    function automatic logic [47:0] ratio_q16(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] frac;
        logic        carry;
        quo = n / d;
        rem = n % d;
        frac = '0;
        if (quo > 64'hFFFF_FFFF)
            return OUT_MAX;
        for (int i = 0; i < 16; i++)
        begin
            carry = rem[63];
            rem = rem << 1;
            frac = frac << 1;
            if (carry || rem >= d)
            begin
                rem = rem - d;
                frac[0] = 1'b1;
            end
        end
        return 48'((quo << 16) | frac);
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // Accumulate one element pair and queue the norm on a vector end.
    task automatic accumulate_pair(input logic signed [23:0] a, input logic signed [23:0] b,
                                   input logic is_last);
        longint      delta;
        logic [63:0] dmag;
        logic [63:0] amag;
        logic [63:0] n;
        logic [63:0] d;
        norm_beat_t  beat;
        delta = longint'(a) - longint'(b);
        dmag = delta < 0 ? -delta : delta;
        amag = a < 0 ? -longint'(a) : longint'(a);
        case (model_kind)
            KIND_INF:
            begin
                if (dmag > diff_sum) diff_sum = dmag;
                if (amag > ref_sum) ref_sum = amag;
            end
            KIND_L1:
            begin
                diff_sum = add_sat(diff_sum, dmag);
                ref_sum = add_sat(ref_sum, amag);
            end
            KIND_L2:
            begin
                diff_sum = add_sat(diff_sum, dmag * dmag);
                ref_sum = add_sat(ref_sum, amag * amag);
            end
            default: ;
        endcase
        if (is_last)
        begin
            if (model_kind == KIND_L2)
            begin
                n = floor_sqrt(diff_sum);
                d = floor_sqrt(ref_sum);
            end
            else if (model_kind == KIND_UNUSED)
            begin
                n = '0;
                d = '0;
            end
            else
            begin
                n = diff_sum;
                d = ref_sum;
            end
            if (d > ONE_Q16)
            begin
                beat.norm_value = ratio_q16(n, d);
                beat.relative = 1'b1;
            end
            else
            begin
                beat.norm_value = n > OUT_MAX ? OUT_MAX : n[47:0];
                beat.relative = 1'b0;
            end
            pending_norms.push_back(beat);
            diff_sum = '0;
            ref_sum = '0;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, actual %0d", what, want, got);
    endtask

    // Result side: random pops and in-order comparison of each beat.
    always @(posedge clk)
    begin
        norm_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_norms.size() == 0)
                note_mismatch("unexpected beat, norm_value", '0, norm_value);
            else
            begin
                want = pending_norms.pop_front();
                if (norm_value !== want.norm_value)
                    note_mismatch("norm_value", want.norm_value, norm_value);
                if (relative !== want.relative)
                    note_mismatch("relative", want.relative, relative);
            end
        end
        pop <= quiet || ($urandom_range(99) >= 26);
    end

    // Send one element pair; push stays high between back-to-back beats.
    task automatic send_pair(input logic signed [23:0] a, input logic signed [23:0] b,
                             input logic is_last);
        if (!quiet && $urandom_range(99) < 26)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        a_value <= a;
        b_value <= b;
        last <= is_last;
        do @(posedge clk); while (full);
        accumulate_pair(a, b, is_last);
    endtask

    // Hold off until every norm has come out and the back end has settled.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending_norms.size() != 0)
            @(posedge clk);
        repeat (BACK_END_CYCLES) @(posedge clk);
    endtask

    task automatic write_kind(input logic [1:0] k);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= k;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_kind = norm_kind_t'(k);
    endtask

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
        endcase
    endfunction

    // Field extremes through the infinity, L1 and L2 kinds.
    task automatic test_extremes();
        for (int k = KIND_INF; k <= KIND_L2; k++)
        begin
            write_kind(k[1:0]);
            send_pair(24'sh800000, 24'sh7FFFFF, 1'b0);
            send_pair(24'sh7FFFFF, 24'sh800000, 1'b1);
            send_pair(24'sh000000, 24'sh7FFFFF, 1'b1);
            send_pair(24'shFFFFFF, 24'sh000001, 1'b1);
        end
    endtask

    // A reference norm of exactly 1.0 stays absolute; just above it divides.
    task automatic test_unit_threshold();
        write_kind(KIND_INF);
        send_pair(24'sd65536, 24'sd0, 1'b1);
        send_pair(24'sd65537, 24'sd1000, 1'b1);
        write_kind(KIND_L1);
        send_pair(24'sd32768, 24'sd0, 1'b0);
        send_pair(24'sd32768, 24'sd5, 1'b1);
    endtask

    // The unused kind accumulates nothing and reports zero.
    task automatic test_unused_kind();
        write_kind(KIND_UNUSED);
        send_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_pair(24'sd12345, 24'sd1, 1'b1);
    endtask

    // Changing kind inside a vector keeps what the accumulators hold.
    task automatic test_kind_change();
        write_kind(KIND_L1);
        send_pair(24'sd200000, 24'sd100, 1'b0);
        write_kind(KIND_L2);
        send_pair(24'sd300000, 24'sd7, 1'b1);
        send_pair(24'sd70000, 24'sd1, 1'b0);
        write_kind(KIND_INF);
        send_pair(24'sd5, 24'sd9, 1'b1);
    endtask

    // Random vector pairs with changing kinds and one quiet stretch.
    task automatic test_random();
        int sent;
        int len;
        int vectors;
        sent = 0;
        vectors = 0;
        while (sent < 1200)
        begin
            if (vectors % 8 == 0)
                write_kind($urandom_range(0, 9) == 0 ? KIND_UNUSED
                                                     : 2'($urandom_range(0, 2)));
            quiet = (sent > 500 && sent < 700);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 80)
                                                : $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                if (i == len / 2 && len > 2 && $urandom_range(0, 11) == 0)
                    write_kind(2'($urandom_range(0, 3)));
                send_pair(pick_value(), pick_value(), i == len - 1);
                sent++;
            end
            vectors++;
        end
        quiet = 1'b0;
    endtask

    // Sequencing of the whole run.
    initial
    begin
        diff_sum = '0;
        ref_sum = '0;
        model_kind = KIND_INF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_unit_threshold();
        test_unused_kind();
        test_kind_change();
        test_random();
        drain();
        if (pending_norms.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
